/* rtl/core/keypad_two_value_entry_core_defines.svh */
// Assertion macros for the keypad entry core.
`ifndef KEYPAD_TWO_VALUE_ENTRY_CORE_DEFINES_SVH
`define KEYPAD_TWO_VALUE_ENTRY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define KPTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad entry check failed");
`define KPTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad entry check failed");
`else
`define KPTE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KPTE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/kpte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kpte_pkg;

    localparam int KEY_COUNT = 16;
    localparam int TARGET_W  = 7;

    localparam logic [TARGET_W-1:0] ANGLE_LIMIT_RESET = 7'd90;

    // floor(x / 10) = (x * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit x
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef enum logic [1:0] {
        TMR_NONE    = 2'd0,
        TMR_STOP    = 2'd1,
        TMR_RESTART = 2'd2
    } timer_cmd_t;

    typedef enum logic [2:0] {
        KEY_NONE  = 3'd0,
        KEY_DIGIT = 3'd1,
        KEY_HASH  = 3'd2,
        KEY_STAR  = 3'd3,
        KEY_OTHER = 3'd4
    } key_kind_t;

    localparam key_kind_t KEY_KIND [0:KEY_COUNT-1] = '{
        KEY_DIGIT, KEY_DIGIT, KEY_DIGIT, KEY_OTHER,
        KEY_DIGIT, KEY_DIGIT, KEY_DIGIT, KEY_OTHER,
        KEY_DIGIT, KEY_DIGIT, KEY_DIGIT, KEY_OTHER,
        KEY_STAR,  KEY_DIGIT, KEY_HASH,  KEY_OTHER
    };

    localparam logic [3:0] KEY_VALUE [0:KEY_COUNT-1] = '{
        4'd1, 4'd2, 4'd3, 4'd0,
        4'd4, 4'd5, 4'd6, 4'd0,
        4'd7, 4'd8, 4'd9, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0
    };

    typedef struct packed {
        logic [KEY_COUNT-1:0] key_matrix;
        logic                 abort_timeout;
    } item_t;

    typedef struct packed {
        logic [TARGET_W-1:0] roll_angle;
        logic [TARGET_W-1:0] pitch_angle;
        logic                display_mode;
        logic [1:0]          timer_command;
        logic [2:0]          entry_phase;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/keypad_two_value_entry_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_two_value_entry_core_defines.svh"

// Channel       | Direction | Handshake             | Word
// --------------+-----------+-----------------------+------------------------------
// item          | in        | item_valid/item_stall | key snapshot, abort flag
// result        | out       | result_valid/stall    | targets, display, timer, phase
// angle_limit   | in        | angle_limit_we        | 7-bit clamp, no read-back
//
// One word in, one word out; a new item is taken every cycle unless item_stall.
// Results go to the output register, or to the skid register while it is held.
// A skid register holds one extra word; item_stall rises only when it is full.
// Reset returns the phase to init, clears the accumulators and targets, limit 90.

module keypad_two_value_entry_core #(
    parameter int ACC_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire kpte_pkg::item_t  item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output kpte_pkg::result_t     result,
    input  wire logic             angle_limit_we,
    input  wire logic [6:0]       angle_limit_data
);

    import kpte_pkg::*;

    typedef enum logic [2:0] {
        PH_INIT  = 3'd0,
        PH_DONE  = 3'd1,
        PH_ROLL  = 3'd2,
        PH_PITCH = 3'd3,
        PH_WAIT  = 3'd4,
        PH_ABORT = 3'd5
    } phase_t;

    phase_t                  phase_reg, phase_next, phase_eff;
    logic [ACC_BITS-1:0]     roll_acc_reg, roll_acc_next;
    logic [ACC_BITS-1:0]     pitch_acc_reg, pitch_acc_next;
    logic [TARGET_W-1:0]     roll_tgt_reg, roll_tgt_next;
    logic [TARGET_W-1:0]     pitch_tgt_reg, pitch_tgt_next;
    logic                    show_reg, show_next;
    logic                    prev_idle_reg;
    logic [TARGET_W-1:0]     limit_reg;

    logic                    out_valid_reg, skid_valid_reg;
    result_t                 out_reg, skid_reg, word_next;

    key_kind_t               kind;
    logic [3:0]              digit;
    logic                    idle, press;
    timer_cmd_t              cmd;

    logic [ACC_BITS-1:0]     sel_acc, acc_mul, acc_div, acc_edit;
    logic [31:0]             div_in;
    logic [63:0]             div_product;
    logic [TARGET_W-1:0]     roll_clamp, pitch_clamp;

    logic                    accept, take;

    assign accept       = item_valid && !skid_valid_reg;
    assign take         = out_valid_reg && !result_stall;
    assign item_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // take the lowest pressed key
    always_comb
    begin
        kind  = KEY_NONE;
        digit = 4'd0;
        for (int i = KEY_COUNT - 1; i >= 0; i--)
        begin
            if (item.key_matrix[i])
            begin
                kind  = KEY_KIND[i];
                digit = KEY_VALUE[i];
            end
        end
    end

    assign idle  = (kind == KEY_NONE);
    assign press = !idle && prev_idle_reg;

    assign phase_eff = item.abort_timeout ? PH_ABORT : phase_reg;

    assign sel_acc     = (phase_eff == PH_PITCH) ? pitch_acc_reg : roll_acc_reg;
    assign acc_mul     = (sel_acc << 3) + (sel_acc << 1) + ACC_BITS'(digit);
    assign div_in      = 32'(sel_acc);
    assign div_product = div_in * DIV10_MAGIC;
    assign acc_div     = ACC_BITS'(div_product >> DIV10_SHIFT);

    assign acc_edit = (kind == KEY_DIGIT) ? acc_mul :
                      (kind == KEY_STAR)  ? acc_div : sel_acc;

    assign roll_clamp  = (roll_acc_reg < ACC_BITS'(limit_reg)) ?
                         roll_acc_reg[TARGET_W-1:0] : limit_reg;
    assign pitch_clamp = (pitch_acc_reg < ACC_BITS'(limit_reg)) ?
                         pitch_acc_reg[TARGET_W-1:0] : limit_reg;

    always_comb
    begin
        phase_next     = phase_eff;
        roll_acc_next  = roll_acc_reg;
        pitch_acc_next = pitch_acc_reg;
        roll_tgt_next  = roll_tgt_reg;
        pitch_tgt_next = pitch_tgt_reg;
        show_next      = show_reg;
        cmd            = (idle != prev_idle_reg) ? TMR_STOP : TMR_NONE;

        case (phase_eff)
            PH_INIT:
            begin
                roll_acc_next  = '0;
                pitch_acc_next = '0;
                roll_tgt_next  = '0;
                pitch_tgt_next = '0;
                phase_next     = PH_WAIT;
            end
            PH_DONE:
            begin
                roll_tgt_next  = roll_clamp;
                pitch_tgt_next = pitch_clamp;
                roll_acc_next  = '0;
                pitch_acc_next = '0;
                phase_next     = PH_WAIT;
            end
            PH_ROLL:
            begin
                show_next = 1'b1;
                if (press)
                begin
                    roll_acc_next = acc_edit;
                    if (kind == KEY_HASH)
                        phase_next = PH_PITCH;
                    if (kind == KEY_STAR)
                        cmd = TMR_RESTART;
                end
            end
            PH_PITCH:
            begin
                if (press)
                begin
                    pitch_acc_next = acc_edit;
                    if (kind == KEY_HASH)
                        phase_next = PH_DONE;
                    if (kind == KEY_STAR)
                        cmd = TMR_RESTART;
                end
            end
            PH_ABORT:
            begin
                roll_acc_next  = '0;
                pitch_acc_next = '0;
                phase_next     = PH_WAIT;
            end
            default:
            begin
                phase_next = PH_WAIT;
                show_next  = 1'b0;
                if (idle && !prev_idle_reg)
                begin
                    phase_next = PH_ROLL;
                    show_next  = 1'b1;
                end
            end
        endcase

        word_next.roll_angle    = roll_tgt_next;
        word_next.pitch_angle   = pitch_tgt_next;
        word_next.display_mode  = show_next;
        word_next.timer_command = cmd;
        word_next.entry_phase   = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_INIT;
            roll_acc_reg   <= '0;
            pitch_acc_reg  <= '0;
            roll_tgt_reg   <= '0;
            pitch_tgt_reg  <= '0;
            show_reg       <= 1'b0;
            prev_idle_reg  <= 1'b0;
            limit_reg      <= ANGLE_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (angle_limit_we)
                limit_reg <= angle_limit_data;

            if (accept)
            begin
                phase_reg     <= phase_next;
                roll_acc_reg  <= roll_acc_next;
                pitch_acc_reg <= pitch_acc_next;
                roll_tgt_reg  <= roll_tgt_next;
                pitch_tgt_reg <= pitch_tgt_next;
                show_reg      <= show_next;
                prev_idle_reg <= idle;

                if (!out_valid_reg || take)
                begin
                    out_reg       <= word_next;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= word_next;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    `KPTE_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `KPTE_ASSERT_NXT(a_full_goes_to_skid, clk, rst_n,
                     accept && out_valid_reg && result_stall, skid_valid_reg)
    `KPTE_ASSERT_IMP(a_no_transient_phase, clk, rst_n, out_valid_reg,
                     out_reg.entry_phase != PH_INIT && out_reg.entry_phase != PH_ABORT)
    `KPTE_ASSERT_NXT(a_timeout_to_wait, clk, rst_n,
                     accept && item.abort_timeout, phase_reg == PH_WAIT)

endmodule

`default_nettype wire
